// ===== sv/spr_pkg.sv =====
// Package for the stream pattern replace block.
// Holds shared constants, the register index codes and the queue item type.
// No dependencies.
`default_nettype none

package spr_pkg;

  // Widths fixed by the register and field definitions.
  localparam int PAT_W         = 64;
  localparam int LEN_W         = 4;
  localparam int BYTE_W        = 8;

  // Window depth default and the replacement length limit.
  localparam int SEARCH_MAX    = 8;
  localparam int REPLACE_MAX   = 8;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_PAT  = 2'd0,
    REG_SEARCH_LEN  = 2'd1,
    REG_REPLACE_PAT = 2'd2,
    REG_REPLACE_LEN = 2'd3
  } cfg_reg_t;

  // One queue item: a run of up to eight result bytes and its end marks.
  // A byte count of zero stands for a single valueless result.
  typedef struct packed {
    logic [PAT_W-1:0] bytes;
    logic [LEN_W-1:0] n;
    logic             last;
    logic             err;
  } emit_t;

endpackage

`default_nettype wire

// ===== sv/spr_front.sv =====
// Front part: configuration registers, the pending byte window and the
// match logic. Turns each accepted item into at most one queue item. Uses spr_pkg.
`default_nettype none

module spr_front #(
  parameter int SEARCH_MAX = spr_pkg::SEARCH_MAX
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spr_pkg::PAT_W-1:0]    cfg_data,
  input  wire logic                         in_fire,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic                         in_has_byte,
  input  wire logic                         in_string_end,
  output      logic                         push,
  output      spr_pkg::emit_t               push_item
);

  localparam int CW = $clog2(SEARCH_MAX + 1);

  logic [spr_pkg::PAT_W-1:0] spat_r;
  logic [spr_pkg::LEN_W-1:0] slen_r;
  logic [spr_pkg::PAT_W-1:0] rpat_r;
  logic [spr_pkg::LEN_W-1:0] rlen_r;

  logic [SEARCH_MAX-1:0][7:0] win_r;
  logic [SEARCH_MAX-1:0][7:0] win_nxt;
  logic [SEARCH_MAX-1:0][7:0] w2;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;

  logic [spr_pkg::LEN_W-1:0] len;
  logic [spr_pkg::LEN_W-1:0] rlen;
  logic [spr_pkg::LEN_W-1:0] c2;
  logic [SEARCH_MAX-1:0]     lane_ok;
  logic                      eq;
  logic                      over;
  logic                      hit;
  logic                      shift;
  logic [spr_pkg::PAT_W-1:0] w2_wide;
  spr_pkg::emit_t            item;

  // Configuration registers; writes must only come while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spat_r <= '0;
      slen_r <= spr_pkg::LEN_W'(1);
      rpat_r <= '0;
      rlen_r <= '0;
    end else if (cfg_valid) begin
      case (spr_pkg::cfg_reg_t'(cfg_index))
        spr_pkg::REG_SEARCH_PAT:  spat_r <= cfg_data;
        spr_pkg::REG_SEARCH_LEN:  slen_r <= cfg_data[spr_pkg::LEN_W-1:0];
        spr_pkg::REG_REPLACE_PAT: rpat_r <= cfg_data;
        spr_pkg::REG_REPLACE_LEN: rlen_r <= cfg_data[spr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths saturate at the window depth and the replacement limit.
  assign len  = (slen_r > spr_pkg::LEN_W'(SEARCH_MAX)) ? spr_pkg::LEN_W'(SEARCH_MAX) : slen_r;
  assign rlen = (rlen_r > spr_pkg::LEN_W'(spr_pkg::REPLACE_MAX)) ?
                spr_pkg::LEN_W'(spr_pkg::REPLACE_MAX) : rlen_r;

  // Append the new byte at the fill position and compare lane by lane.
  always_comb begin
    for (int i = 0; i < SEARCH_MAX; i++) begin
      w2[i]      = (in_has_byte && (cnt_r == CW'(i))) ? in_data_byte : win_r[i];
      lane_ok[i] = (spr_pkg::LEN_W'(i) >= len) || (w2[i] == spat_r[8*i +: 8]);
    end
  end

  assign c2   = spr_pkg::LEN_W'(cnt_r) + spr_pkg::LEN_W'(in_has_byte);
  assign eq   = in_has_byte && (c2 == len);
  assign over = in_has_byte && (c2 > len);
  assign hit  = eq && (&lane_ok);

  always_comb begin
    w2_wide                     = '0;
    w2_wide[SEARCH_MAX*8-1:0]   = w2;
  end

  // Decide what this item emits and what the window keeps.
  always_comb begin
    item      = '0;
    item.last = in_string_end;
    cnt_nxt   = '0;
    shift     = 1'b0;
    push      = 1'b0;
    if (len == '0) begin
      // Zero search length drops bytes and flags the string end.
      item.err = 1'b1;
      push     = in_fire && in_string_end;
    end else begin
      if (hit) begin
        item.bytes = rpat_r;
        item.n     = rlen;
      end else if (in_string_end || over) begin
        item.bytes = w2_wide;
        item.n     = c2;
      end else if (eq) begin
        item.bytes = w2_wide;
        item.n     = spr_pkg::LEN_W'(1);
        cnt_nxt    = CW'(c2 - spr_pkg::LEN_W'(1));
        shift      = 1'b1;
      end else begin
        cnt_nxt    = CW'(c2);
      end
      push = in_fire && ((item.n != '0) || in_string_end);
    end
  end

  assign win_nxt   = shift ? (w2 >> 8) : w2;
  assign push_item = item;

  // Window fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Window bytes; only entries below the fill count are ever used.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/spr_queue.sv =====
// Short item queue between the front and back parts of the block.
// Register based, one write and one read per cycle. Uses spr_pkg.
`default_nettype none

module spr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire spr_pkg::emit_t push_item,
  input  wire logic           pop,
  output      spr_pkg::emit_t head_item,
  output      logic           empty,
  output      logic           full
);

  spr_pkg::emit_t              mem_r [spr_pkg::QUEUE_DEPTH];
  logic [spr_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [spr_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [spr_pkg::QCNT_W-1:0]  cnt_r;
  logic [spr_pkg::QCNT_W-1:0]  cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == spr_pkg::QCNT_W'(spr_pkg::QUEUE_DEPTH));
  assign head_item = mem_r[rd_ptr_r];

  // Occupancy follows push and pop together.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + spr_pkg::QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - spr_pkg::QCNT_W'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + spr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + spr_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/spr_back.sv =====
// Back part: takes queue items and sends their results one per cycle,
// while out_ready is high, through a registered output stage. Uses spr_pkg.
`default_nettype none

module spr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire spr_pkg::emit_t head_item,
  input  wire logic           empty,
  output      logic           pop,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      logic [7:0]     out_out_byte,
  output      logic           out_out_valid,
  output      logic           out_out_last,
  output      logic           out_error
);

  logic [spr_pkg::PAT_W-1:0] cur_bytes_r;
  logic [spr_pkg::LEN_W-1:0] cur_rem_r;
  logic                      cur_data_r;
  logic                      cur_last_r;
  logic                      cur_err_r;
  logic                      cur_v_r;
  logic                      cur_v_nxt;

  logic                      ov_r;
  logic [7:0]                obyte_r;
  logic                      odata_r;
  logic                      olast_r;
  logic                      oerr_r;

  logic                      out_load;
  logic                      cur_fire;
  logic                      cur_done;

  // The output register takes a result when it is empty or being drained.
  assign out_load = !ov_r || out_ready;
  assign cur_fire = cur_v_r && out_load;
  assign cur_done = (cur_rem_r <= spr_pkg::LEN_W'(1));
  assign pop      = !empty && (!cur_v_r || (cur_fire && cur_done));

  always_comb begin
    cur_v_nxt = cur_v_r;
    if (pop) begin
      cur_v_nxt = 1'b1;
    end else if (cur_fire && cur_done) begin
      cur_v_nxt = 1'b0;
    end
  end

  // Current item valid flag and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      if (out_load) begin
        ov_r <= cur_v_r;
      end
    end
  end

  // Current item: load from the queue, or step to the next byte.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bytes_r <= head_item.bytes;
      cur_rem_r   <= (head_item.n == '0) ? spr_pkg::LEN_W'(1) : head_item.n;
      cur_data_r  <= (head_item.n != '0);
      cur_last_r  <= head_item.last;
      cur_err_r   <= head_item.err;
    end else if (cur_fire) begin
      cur_bytes_r <= cur_bytes_r >> 8;
      cur_rem_r   <= cur_rem_r - spr_pkg::LEN_W'(1);
    end
  end

  // Output payload; a valueless result carries a zero byte.
  always_ff @(posedge clk) begin
    if (cur_fire) begin
      obyte_r <= cur_data_r ? cur_bytes_r[7:0] : 8'd0;
      odata_r <= cur_data_r;
      olast_r <= cur_last_r && cur_done;
      oerr_r  <= cur_err_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_out_byte  = obyte_r;
  assign out_out_valid = odata_r;
  assign out_out_last  = olast_r;
  assign out_error     = oerr_r;

endmodule

`default_nettype wire

// ===== sv/stream_pattern_replace_core.sv =====
// Stream pattern replace: top level joining front, queue and back parts.
// An accepted item goes into the queue, then the current-item register, then the output stage.
// Throughput: one item per cycle in while the queue is not full; one result per cycle out while
// out_ready is high. An item with n results holds the output; the four-entry queue absorbs bursts.
// Reset (synchronous, rst_n low) empties the window, queue and output stage and
// restores the registers: search length one, all else zero. Uses spr_pkg.
`default_nettype none

module stream_pattern_replace_core #(
  parameter int SEARCH_MAX = spr_pkg::SEARCH_MAX
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spr_pkg::PAT_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_has_byte,
  input  wire logic                          in_string_end,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [7:0]                    out_out_byte,
  output      logic                          out_out_valid,
  output      logic                          out_out_last,
  output      logic                          out_error
);

  logic           in_fire;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  spr_pkg::emit_t push_item;
  spr_pkg::emit_t head_item;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  spr_front #(
    .SEARCH_MAX (SEARCH_MAX)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_fire       (in_fire),
    .in_data_byte  (in_data_byte),
    .in_has_byte   (in_has_byte),
    .in_string_end (in_string_end),
    .push          (push),
    .push_item     (push_item)
  );

  spr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  spr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (head_item),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_out_valid (out_out_valid),
    .out_out_last  (out_out_last),
    .out_error     (out_error)
  );

endmodule

`default_nettype wire

// ===== sv/spr_checker.sv =====
// Port-level checks on the result channel of the stream pattern replace
// top level, with the bind that attaches them. No package dependencies.
`default_nettype none

module spr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_out_valid,
  input wire logic       out_out_last,
  input wire logic       out_error
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte) &&
    $stable(out_out_valid) && $stable(out_out_last) && $stable(out_error))
    else $error("result changed while stalled");

  // A valueless result is the end of its string and carries a zero byte.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_last && (out_out_byte == 8'd0))
    else $error("valueless result without end mark or with a byte");

  // An error result carries no byte and closes the string.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_out_valid && out_out_last)
    else $error("malformed error result");

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind stream_pattern_replace_core spr_checker u_spr_checker (.*);

`default_nettype wire

// ===== sim/stream_pattern_replace_core_test.sv =====
// Self-checking testbench for stream_pattern_replace_core: find and replace on a byte stream.
// It drives bytes and register writes and predicts each rewritten byte in its own model.
// Depends on spr_pkg and the stream_pattern_replace_core RTL.
module stream_pattern_replace_core_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 120;
  localparam int IDLE_PCT     = 15;
  localparam int SHOW_LIMIT   = 10;

  // One input item and one result, at the widths of the ports.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       err;
  } text_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  spr_pkg::cfg_reg_t cfg_index = spr_pkg::REG_SEARCH_PAT;
  logic [spr_pkg::PAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic in_has_byte = 1'b0;
  logic in_string_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic out_out_valid;
  logic out_out_last;
  logic out_error;

  // Items waiting to be driven and results still to arrive.
  text_item_t text_feed[$];
  text_out_t rewritten_q[$];

  // Predictor copy of the registers and the match window.
  logic [spr_pkg::PAT_W-1:0] srch_pat = '0;
  logic [spr_pkg::LEN_W-1:0] srch_len = 4'd1;
  logic [spr_pkg::PAT_W-1:0] repl_pat = '0;
  logic [spr_pkg::LEN_W-1:0] repl_len = 4'd0;
  logic [7:0] win_bytes[spr_pkg::SEARCH_MAX];
  int win_count = 0;

  int fail_count = 0;
  int items_taken = 0;
  int cycle_count = 0;
  int stall_at = 1 << 30;
  int stall_left = 0;
  logic stall_done = 1'b0;
  int calm_from = 0;
  int calm_to = 0;

  // Inside the calm stretch neither side idles.
  wire calm = (items_taken >= calm_from) && (items_taken < calm_to);

  stream_pattern_replace_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_has_byte(in_has_byte),
    .in_string_end(in_string_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_out_byte(out_out_byte),
    .out_out_valid(out_out_valid),
    .out_out_last(out_out_last),
    .out_error(out_error)
  );

  always #5 clk = ~clk;

  // Appends one result to the expected store.
  task automatic emit(input logic [7:0] b, input logic v, input logic l, input logic e,
                      inout int produced);
    text_out_t r;
    r = '{data: b, valid: v, last: l, err: e};
    rewritten_q.push_back(r);
    produced++;
  endtask

  // Emits every byte held in the window, oldest first, and empties it.
  task automatic flush_window(inout int produced);
    int i;
    for (i = 0; i < win_count; i++) emit(win_bytes[i], 1'b1, 1'b0, 1'b0, produced);
    win_count = 0;
  endtask

  // Works out the results of one accepted item.
  task automatic rewrite_item(input text_item_t it);
    int slen;
    int rlen;
    int produced;
    int i;
    logic hit;
    slen = (srch_len > spr_pkg::SEARCH_MAX) ? spr_pkg::SEARCH_MAX : int'(srch_len);
    rlen = (repl_len > spr_pkg::REPLACE_MAX) ? spr_pkg::REPLACE_MAX : int'(repl_len);
    produced = 0;
    // An empty search pattern drops the string and flags it at its end.
    if (slen == 0) begin
      win_count = 0;
      if (it.eos) emit(8'h00, 1'b0, 1'b1, 1'b1, produced);
      return;
    end
    if (it.has) begin
      if (win_count >= spr_pkg::SEARCH_MAX) flush_window(produced);
      win_bytes[win_count] = it.data;
      win_count++;
      if (win_count > slen) begin
        flush_window(produced);
      end else if (win_count == slen) begin
        hit = 1'b1;
        for (i = 0; i < slen; i++) begin
          if (win_bytes[i] !== srch_pat[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) emit(repl_pat[8*i +: 8], 1'b1, 1'b0, 1'b0, produced);
          win_count = 0;
        end else begin
          emit(win_bytes[0], 1'b1, 1'b0, 1'b0, produced);
          for (i = 1; i < win_count; i++) win_bytes[i-1] = win_bytes[i];
          win_count--;
        end
      end
    end
    // At string end the leftovers go out and the final result carries the mark.
    if (it.eos) begin
      flush_window(produced);
      if (produced == 0) emit(8'h00, 1'b0, 1'b1, 1'b0, produced);
      else rewritten_q[rewritten_q.size()-1].last = 1'b1;
      win_count = 0;
    end
  endtask

  task automatic flag_error(input string what, input text_out_t want, input text_out_t got);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("%s: expected byte %02h valid %0d last %0d err %0d,", what,
               want.data, want.valid, want.last, want.err);
      $display("  got byte %02h valid %0d last %0d err %0d",
               got.data, got.valid, got.last, got.err);
    end
  endtask

  // Sender: offers queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    text_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rewrite_item('{data: in_data_byte, has: in_has_byte, eos: in_string_end});
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (text_feed.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = text_feed.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_has_byte <= nxt.has;
          in_string_end <= nxt.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and throttles out_ready.
  always @(posedge clk) begin
    text_out_t got;
    text_out_t want;
    got = '{data: out_out_byte, valid: out_out_valid, last: out_out_last, err: out_error};
    if (rst_n && out_valid && out_ready) begin
      if (rewritten_q.size() == 0) begin
        flag_error("unexpected result", '0, got);
      end else begin
        want = rewritten_q.pop_front();
        if (got.data !== want.data || got.valid !== want.valid ||
            got.last !== want.last || got.err !== want.err) begin
          flag_error("result mismatch", want, got);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && items_taken >= stall_at) begin
      // One long hold-off so that the block fills and pushes back on its input.
      out_ready <= 1'b0;
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic [7:0] b, input logic has, input logic eos);
    text_feed.push_back('{data: b, has: has, eos: eos});
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input spr_pkg::cfg_reg_t idx,
                           input logic [spr_pkg::PAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spr_pkg::REG_SEARCH_PAT:  srch_pat = value;
      spr_pkg::REG_SEARCH_LEN:  srch_len = value[spr_pkg::LEN_W-1:0];
      spr_pkg::REG_REPLACE_PAT: repl_pat = value;
      spr_pkg::REG_REPLACE_LEN: repl_len = value[spr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [spr_pkg::PAT_W-1:0] spat,
                          input logic [spr_pkg::PAT_W-1:0] slen,
                          input logic [spr_pkg::PAT_W-1:0] rpat,
                          input logic [spr_pkg::PAT_W-1:0] rlen);
    write_reg(spr_pkg::REG_SEARCH_PAT, spat);
    write_reg(spr_pkg::REG_SEARCH_LEN, slen);
    write_reg(spr_pkg::REG_REPLACE_PAT, rpat);
    write_reg(spr_pkg::REG_REPLACE_LEN, rlen);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item is taken and every result is in, then lets the pipeline drain.
  task automatic settle();
    @(posedge clk);
    while (text_feed.size() != 0 || in_valid || rewritten_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Queues one string built mostly from copies and prefixes of the search pattern.
  task automatic add_random_string(inout int counted);
    text_item_t chunk[$];
    int nbytes;
    int glen;
    int plen;
    int j;
    int pick;
    glen = (srch_len == 0) ? 1 :
           ((srch_len > spr_pkg::SEARCH_MAX) ? spr_pkg::SEARCH_MAX : int'(srch_len));
    nbytes = $urandom_range(12);
    while (chunk.size() < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        chunk.push_back('{data: 8'($urandom), has: 1'b0, eos: 1'b0});
      end else if (pick < 45) begin
        plen = ($urandom_range(99) < 65) ? glen : $urandom_range(glen, 1);
        for (j = 0; j < plen; j++) begin
          chunk.push_back('{data: srch_pat[8*j +: 8], has: 1'b1, eos: 1'b0});
        end
      end else if (pick < 70) begin
        j = $urandom_range(glen - 1);
        chunk.push_back('{data: srch_pat[8*j +: 8], has: 1'b1, eos: 1'b0});
      end else begin
        chunk.push_back('{data: 8'($urandom), has: 1'b1, eos: 1'b0});
      end
    end
    // The end mark rides on the last byte or comes alone without a byte.
    if (chunk.size() == 0 || $urandom_range(3) == 0) begin
      chunk.push_back('{data: 8'($urandom), has: 1'b0, eos: 1'b1});
    end else begin
      chunk[chunk.size()-1].eos = 1'b1;
    end
    foreach (chunk[k]) begin
      text_feed.push_back(chunk[k]);
      if (chunk[k].has || chunk[k].eos) counted++;
    end
  endtask

  task automatic run_phase(input logic [spr_pkg::PAT_W-1:0] spat,
                           input logic [spr_pkg::PAT_W-1:0] slen,
                           input logic [spr_pkg::PAT_W-1:0] rpat,
                           input logic [spr_pkg::PAT_W-1:0] rlen,
                           input int target);
    int counted;
    counted = 0;
    set_regs(spat, slen, rpat, rlen);
    while (counted < target) add_random_string(counted);
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings delete every zero byte; also an ignored item and an empty string.
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hA5, 1'b0, 1'b1);
    settle();

    // Replace "abc" by "Z": a match, a miss with leftovers, then a string left open.
    set_regs(64'h63_6261, 64'd3, 64'h5A, 64'd1);
    add_item("a", 1'b1, 1'b0);
    add_item("b", 1'b1, 1'b0);
    add_item("c", 1'b1, 1'b0);
    add_item("a", 1'b1, 1'b0);
    add_item("b", 1'b1, 1'b0);
    add_item("x", 1'b1, 1'b1);
    add_item("a", 1'b1, 1'b0);
    add_item("b", 1'b1, 1'b0);
    settle();

    // The search length shrinks while two bytes sit in the window.
    set_regs(64'h71, 64'd1, 64'h5A, 64'd1);
    add_item("q", 1'b1, 1'b0);
    add_item("q", 1'b1, 1'b1);
    settle();

    // An empty search pattern flags an error for each string.
    set_regs(64'h71, 64'd0, 64'h5A, 64'd1);
    add_item(8'h11, 1'b1, 1'b0);
    add_item(8'h22, 1'b1, 1'b1);
    add_item(8'h33, 1'b0, 1'b1);
    settle();

    // Both lengths above their limits saturate to eight bytes.
    set_regs(64'h0123_4567_89AB_CDEF, 64'd15, 64'h8877_6655_4433_2211, 64'd15);
    add_item(8'hEF, 1'b1, 1'b0);
    add_item(8'hCD, 1'b1, 1'b0);
    add_item(8'hAB, 1'b1, 1'b0);
    add_item(8'h89, 1'b1, 1'b0);
    add_item(8'h67, 1'b1, 1'b0);
    add_item(8'h45, 1'b1, 1'b0);
    add_item(8'h23, 1'b1, 1'b0);
    add_item(8'h01, 1'b1, 1'b1);
    settle();

    // Random strings under several settings; the first one carries the long hold-off.
    stall_at = items_taken + 5;
    run_phase({$urandom, $urandom}, 64'($urandom_range(4, 2)), {$urandom, $urandom},
              64'($urandom_range(8)), 30);
    run_phase({spr_pkg::PAT_W{1'b1}}, 64'd8, 64'h0, 64'd0, 12);
    run_phase({$urandom, $urandom}, 64'd1, {spr_pkg::PAT_W{1'b1}}, 64'd8, 12);
    run_phase({$urandom, $urandom}, 64'd0, {$urandom, $urandom}, 64'd3, 8);
    calm_from = items_taken;
    calm_to = items_taken + 20;
    run_phase({$urandom, $urandom}, 64'd12, {$urandom, $urandom}, 64'd15, 10);
    run_phase({$urandom, $urandom}, 64'($urandom_range(8, 1)), 64'h0,
              64'($urandom_range(8)), 12);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && rewritten_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
